// File: sv/efm_pkg.sv
// Shared types, codes and constants of the escape-time fractal metric block.
package efm_pkg;

	localparam int unsigned ITW = 10;
	localparam int unsigned MW = 31;
	localparam logic [ITW-1:0] ITER_CAP = '1;
	localparam logic [MW-1:0] METRIC_SAT = '1;

	localparam logic [2:0] CFG_SET_KIND = 3'd0;
	localparam logic [2:0] CFG_COLOR_MODE = 3'd1;
	localparam logic [2:0] CFG_JULIA_RE = 3'd2;
	localparam logic [2:0] CFG_JULIA_IM = 3'd3;
	localparam logic [2:0] CFG_ESC_RADIUS = 3'd4;

	localparam logic signed [31:0] JULIA_RE_RST = 32'sd53687091;
	localparam logic signed [31:0] JULIA_IM_RST = -32'sd139586437;
	localparam logic [30:0] ESC_RADIUS_RST = 31'd536870912;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MRR, OP_MII, OP_MRI, OP_NEXT, OP_MNR, OP_MNI,
		OP_SQS, OP_MAG, OP_MMM, OP_ACC, OP_NOESC, OP_LNQ, OP_SMUL, OP_KNQ,
		OP_LSS, OP_KSS, OP_LNN, OP_LDIV, OP_DIV, OP_DSQ, OP_DEV
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MRR, ST_MII, ST_MRI, ST_NEXT, ST_MNR, ST_MNI, ST_SQS, ST_SQW,
		ST_MAG, ST_MMM, ST_ACC, ST_CHK, ST_NOESC, ST_LNQ, ST_MNQ, ST_KNQ, ST_LSS,
		ST_MSS, ST_KSS, ST_LNN, ST_MNN, ST_LDIV, ST_DIV, ST_DSQ, ST_DSW, ST_DEV,
		ST_OUT
	} st_t;

	typedef struct packed {
		op_t op;
		logic push;
	} ctrl_cmd_t;

	typedef struct packed {
		logic esc;
		logic last;
		logic mul_done;
		logic div_busy;
		logic sqrt_busy;
	} dp_sts_t;

	function automatic logic [ITW-1:0] iter_sat(input logic [31:0] v);
		return (v > 32'(ITER_CAP)) ? ITER_CAP : v[ITW-1:0];
	endfunction

endpackage

// File: sv/efm_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module efm_sqrt import efm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] din,
	output logic        busy,
	output logic [31:0] root
);
	logic [5:0]  cnt_q;
	logic [63:0] v_q, res_q, bit_q, trial;

	assign trial = res_q + bit_q;
	assign busy = (cnt_q != '0);
	assign root = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= din;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// File: sv/efm_ctrl.sv
// Controller: sequences one point through iterations and the metric finish.
module efm_ctrl import efm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      color_mode,
	input  logic      out_free,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);
	st_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		cmd.op = OP_NONE;
		cmd.push = 1'b0;
		in_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					st_d = ST_MRR;
				end
			end
			ST_MRR: begin cmd.op = OP_MRR; st_d = ST_MII; end
			ST_MII: begin cmd.op = OP_MII; st_d = ST_MRI; end
			ST_MRI: begin cmd.op = OP_MRI; st_d = ST_NEXT; end
			ST_NEXT: begin cmd.op = OP_NEXT; st_d = ST_MNR; end
			ST_MNR: begin cmd.op = OP_MNR; st_d = ST_MNI; end
			ST_MNI: begin cmd.op = OP_MNI; st_d = ST_SQS; end
			ST_SQS: begin cmd.op = OP_SQS; st_d = ST_SQW; end
			ST_SQW: begin
				if (!sts.sqrt_busy) st_d = ST_MAG;
			end
			ST_MAG: begin cmd.op = OP_MAG; st_d = ST_MMM; end
			ST_MMM: begin cmd.op = OP_MMM; st_d = ST_ACC; end
			ST_ACC: begin cmd.op = OP_ACC; st_d = ST_CHK; end
			ST_CHK: begin
				if (sts.esc) begin
					st_d = color_mode ? ST_LNQ : ST_OUT;
				end else if (sts.last) begin
					st_d = ST_NOESC;
				end else begin
					st_d = ST_MRR;
				end
			end
			ST_NOESC: begin cmd.op = OP_NOESC; st_d = ST_OUT; end
			ST_LNQ: begin cmd.op = OP_LNQ; st_d = ST_MNQ; end
			ST_MNQ: begin
				cmd.op = OP_SMUL;
				if (sts.mul_done) st_d = ST_KNQ;
			end
			ST_KNQ: begin cmd.op = OP_KNQ; st_d = ST_LSS; end
			ST_LSS: begin cmd.op = OP_LSS; st_d = ST_MSS; end
			ST_MSS: begin
				cmd.op = OP_SMUL;
				if (sts.mul_done) st_d = ST_KSS;
			end
			ST_KSS: begin cmd.op = OP_KSS; st_d = ST_LNN; end
			ST_LNN: begin cmd.op = OP_LNN; st_d = ST_MNN; end
			ST_MNN: begin
				cmd.op = OP_SMUL;
				if (sts.mul_done) st_d = ST_LDIV;
			end
			ST_LDIV: begin cmd.op = OP_LDIV; st_d = ST_DIV; end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (!sts.div_busy) st_d = ST_DSQ;
			end
			ST_DSQ: begin cmd.op = OP_DSQ; st_d = ST_DSW; end
			ST_DSW: begin
				if (!sts.sqrt_busy) st_d = ST_DEV;
			end
			ST_DEV: begin cmd.op = OP_DEV; st_d = ST_OUT; end
			ST_OUT: begin
				if (out_free) begin
					cmd.push = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end
endmodule

// File: sv/efm_dp.sv
// Datapath: shared multiplier, magnitude sums, serial multiply, divider, root.
module efm_dp import efm_pkg::*; #(
	parameter int unsigned MAX_ITER = 1000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  logic [63:0]        point,
	input  logic               set_kind,
	input  logic signed [31:0] julia_re,
	input  logic signed [31:0] julia_im,
	input  logic [30:0]        escape_radius,
	output dp_sts_t            sts,
	output logic               res_escaped,
	output logic [ITW-1:0]     res_iterations,
	output logic [MW-1:0]      res_metric
);
	localparam int unsigned KW = $clog2(MAX_ITER + 1);
	localparam int unsigned SW = 32 + KW;
	localparam int unsigned QW = 64 + KW;
	localparam int unsigned DW = 64 + 2 * KW;
	localparam int unsigned CW = $clog2(DW + 1);
	localparam int unsigned NW = 2 * KW;

	logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
	logic signed [65:0] mp_q, rr_q, ii_q;
	logic signed [37:0] nr_q, ni_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] diff;
	logic [31:0] mag_q, prev_q, step_diff;
	logic [KW-1:0] k_q, it_q;
	logic [SW-1:0] sum_q;
	logic [QW-1:0] sq_q;
	logic [DW-1:0] ma_q, acc_q, d_q, num_q;
	logic [SW-1:0] mb_q;
	logic [NW-1:0] dv_q;
	logic [NW:0] rem_q, rem_sh;
	logic [63:0] quo_q, sq_din;
	logic [CW-1:0] dcnt_q;
	logic esc_q, ok_r, ok_i, esc;
	logic sq_start, sq_busy;
	logic [31:0] root;

	always_comb begin
		mul_a = 33'(zr_q);
		mul_b = 33'(zr_q);
		case (cmd.op)
			OP_MII: begin mul_a = 33'(zi_q); mul_b = 33'(zi_q); end
			OP_MRI: begin mul_a = 33'(zr_q); mul_b = 33'(zi_q); end
			OP_MNR: begin
				mul_a = 33'($signed(nr_q[31:0]));
				mul_b = 33'($signed(nr_q[31:0]));
			end
			OP_MNI: begin
				mul_a = 33'($signed(ni_q[31:0]));
				mul_b = 33'($signed(ni_q[31:0]));
			end
			OP_MMM: begin
				mul_a = $signed({1'b0, mag_q});
				mul_b = $signed({1'b0, mag_q});
			end
			default: ;
		endcase
	end

	assign diff = rr_q - ii_q;
	// component in range iff strictly inside (-2^31, 2^31)
	assign ok_r = (nr_q[37:31] == '0) || ((&nr_q[37:31]) && (|nr_q[30:0]));
	assign ok_i = (ni_q[37:31] == '0) || ((&ni_q[37:31]) && (|ni_q[30:0]));
	assign esc = (mag_q > {1'b0, escape_radius});
	assign step_diff = mag_q - prev_q;
	assign rem_sh = {rem_q[NW-1:0], num_q[DW-1]};

	assign sq_start = (cmd.op == OP_SQS) || (cmd.op == OP_DSQ);
	assign sq_din = (cmd.op == OP_DSQ) ? quo_q : (rr_q[63:0] + mp_q[63:0]);

	efm_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .din(sq_din),
		.busy(sq_busy), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.op == OP_LDIV) begin
			dcnt_q <= CW'(DW);
		end else if (cmd.op == OP_DIV && dcnt_q != '0) begin
			dcnt_q <= dcnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				if (set_kind) begin
					zr_q <= $signed(point[31:0]);
					zi_q <= $signed(point[63:32]);
					cr_q <= julia_re;
					ci_q <= julia_im;
				end else begin
					zr_q <= '0;
					zi_q <= '0;
					cr_q <= $signed(point[31:0]);
					ci_q <= $signed(point[63:32]);
				end
				k_q <= '0;
				prev_q <= '0;
				sum_q <= '0;
				sq_q <= '0;
			end
			OP_MRR: mp_q <= mul_a * mul_b;
			OP_MII: begin rr_q <= mp_q; mp_q <= mul_a * mul_b; end
			OP_MRI: begin ii_q <= mp_q; mp_q <= mul_a * mul_b; end
			OP_NEXT: begin
				nr_q <= 38'(diff >>> 28) + 38'(cr_q);
				ni_q <= 38'(mp_q >>> 27) + 38'(ci_q);
			end
			OP_MNR: mp_q <= mul_a * mul_b;
			OP_MNI: begin rr_q <= mp_q; mp_q <= mul_a * mul_b; end
			OP_MAG: mag_q <= (ok_r && ok_i) ? root : 32'hFFFF_FFFF;
			OP_MMM: begin
				mp_q <= mul_a * mul_b;
				sum_q <= sum_q + SW'(mag_q);
			end
			OP_ACC: begin
				sq_q <= sq_q + QW'(mp_q[63:0]);
				esc_q <= esc;
				it_q <= k_q;
				k_q <= k_q + KW'(1);
				res_metric <= (mag_q < prev_q || step_diff[31]) ? METRIC_SAT
					: step_diff[MW-1:0];
				prev_q <= mag_q;
				zr_q <= nr_q[31:0];
				zi_q <= ni_q[31:0];
			end
			OP_NOESC: begin
				esc_q <= 1'b0;
				res_metric <= '0;
			end
			OP_LNQ: begin ma_q <= DW'(sq_q); mb_q <= SW'(k_q); acc_q <= '0; end
			OP_LSS: begin ma_q <= DW'(sum_q); mb_q <= sum_q; acc_q <= '0; end
			OP_LNN: begin ma_q <= DW'(k_q); mb_q <= SW'(k_q); acc_q <= '0; end
			OP_SMUL: begin
				if (mb_q[0]) acc_q <= acc_q + ma_q;
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end
			OP_KNQ: d_q <= acc_q;
			OP_KSS: d_q <= d_q - acc_q;
			OP_LDIV: begin
				dv_q <= acc_q[NW-1:0];
				num_q <= d_q;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DIV: begin
				if (dcnt_q != '0) begin
					if (rem_sh >= {1'b0, dv_q}) begin
						rem_q <= rem_sh - {1'b0, dv_q};
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					num_q <= num_q << 1;
				end
			end
			OP_DEV: res_metric <= root[31] ? METRIC_SAT : root[MW-1:0];
			default: ;
		endcase
	end

	assign sts.esc = esc_q;
	assign sts.last = (k_q == KW'(MAX_ITER));
	assign sts.mul_done = (mb_q == '0);
	assign sts.div_busy = (dcnt_q != '0);
	assign sts.sqrt_busy = sq_busy;

	assign res_escaped = esc_q;
	assign res_iterations = esc_q ? iter_sat(32'(it_q)) : iter_sat(32'(MAX_ITER));
endmodule

// File: sv/escape_time_fractal_metric.sv
// Escape-time fractal metric, Mandelbrot or Julia, top level.
// Usage:
//   s_* channel: one beat per point (re, im in signed Q4.28).
//   m_* channel: one beat per point: escaped flag, iteration index, color metric.
//   cfg channel: register writes, always ready; write only while the block is idle.
// Timing: one point at a time. Each iteration is paced by the
//   shared 33x33 multiplier (six products) and the 32-step square root unit.
//   With the deviation metric a finish follows: bit-serial multiplies (one bit
//   of the multiplier per cycle), a restoring divider with its load step and
//   another square root.
// A finished result sits in the output register; the next point is accepted
// while it waits. If the receiver stalls and a second result is ready, the
// controller holds it until the output register frees.
// Reset: clears the controller and output valid, and loads the register
// defaults (Mandelbrot, step metric, c = 0.2 - 0.52i, radius 2.0).
module escape_time_fractal_metric import efm_pkg::*; #(
	parameter int unsigned MAX_ITER = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // point_re[31:0], point_im[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // iterations[9:0], color_metric[40:10], zero fill
	output logic        m_tuser,   // escaped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic set_kind_q, color_mode_q;
	logic signed [31:0] julia_re_q, julia_im_q;
	logic [30:0] radius_q;
	ctrl_cmd_t cmd;
	dp_sts_t sts;
	logic out_free, res_escaped;
	logic [ITW-1:0] res_iterations;
	logic [MW-1:0] res_metric;
	logic out_valid_q, out_esc_q;
	logic [ITW-1:0] out_iter_q;
	logic [MW-1:0] out_metric_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_kind_q <= 1'b0;
			color_mode_q <= 1'b0;
			julia_re_q <= JULIA_RE_RST;
			julia_im_q <= JULIA_IM_RST;
			radius_q <= ESC_RADIUS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SET_KIND: set_kind_q <= cfg_data[0];
				CFG_COLOR_MODE: color_mode_q <= cfg_data[0];
				CFG_JULIA_RE: julia_re_q <= $signed(cfg_data);
				CFG_JULIA_IM: julia_im_q <= $signed(cfg_data);
				CFG_ESC_RADIUS: radius_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;

	efm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.color_mode(color_mode_q), .out_free(out_free), .sts(sts), .cmd(cmd)
	);

	efm_dp #(.MAX_ITER(MAX_ITER)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .point(s_tdata),
		.set_kind(set_kind_q), .julia_re(julia_re_q), .julia_im(julia_im_q),
		.escape_radius(radius_q), .sts(sts), .res_escaped(res_escaped),
		.res_iterations(res_iterations), .res_metric(res_metric)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_esc_q <= res_escaped;
			out_iter_q <= res_iterations;
			out_metric_q <= res_metric;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_esc_q;
	assign m_tdata = {7'd0, out_metric_q, out_iter_q};
endmodule

// File: sv/efm_checker.sv
// Port-level checks for the escape-time fractal metric top level.
module efm_checker import efm_pkg::*; #(
	parameter int unsigned MAX_ITER = 1000
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);
	localparam logic [ITW-1:0] NOESC_ITER =
		(MAX_ITER > 1023) ? ITER_CAP : ITW'(MAX_ITER);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a point is in work");

	a_noesc_metric: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[40:10] == '0)
		else $error("non-escaped point with nonzero metric");

	a_noesc_iter: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[9:0] == NOESC_ITER)
		else $error("non-escaped point with wrong iteration count");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:41] == '0)
		else $error("result padding not zero");
endmodule

bind escape_time_fractal_metric efm_checker #(.MAX_ITER(MAX_ITER)) u_efm_checker (.*);
